@@ src/etrb_pkg.sv @@
// ----------------------------------------------------------------------------
// etrb_pkg
// types, constants and helpers shared by the trace ring buffer modules
// ----------------------------------------------------------------------------
package etrb_pkg;

  // field widths
  localparam int CMD_W     = 1;
  localparam int TAG_W     = 8;
  localparam int FLAG_W    = 8;
  localparam int PAYLOAD_W = 32;
  localparam int TIME_W    = 32;
  localparam int SEQ_W     = 16;
  localparam int LIMIT_W   = 7;
  localparam int CFG_W     = 4;

  // ring and tag table geometry
  localparam int RING_DEPTH   = 16;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int TAG_SLOTS    = 8;
  localparam int TAG_AW       = $clog2(TAG_SLOTS);
  localparam int MAX_READ     = 64;
  localparam int PAYLOAD_BITS = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // lost counter saturates at what both 32 bits and the payload can hold
  localparam logic [PAYLOAD_W-1:0] LOST_MAX = (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF :
                                              32'((64'd1 << PAYLOAD_BITS) - 64'd1);

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } bk_state_t;

  // one classified command as it travels through the queue
  typedef struct packed {
    cmd_t                 kind;
    logic [TAG_W-1:0]     tag;
    logic [FLAG_W-1:0]    flags;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    stamp;
    logic [LIMIT_W-1:0]   limit;
  } item_t;

  function automatic logic [RING_AW-1:0] next_ring_idx(input logic [RING_AW-1:0] idx);
    if (idx == RING_AW'(RING_DEPTH - 1)) begin
      return '0;
    end
    return idx + RING_AW'(1);
  endfunction

endpackage

@@ src/etrb_front.sv @@
// ----------------------------------------------------------------------------
// etrb_front
// accepts input beats, clamps the read limit and drops empty reads
// ----------------------------------------------------------------------------
module etrb_front import etrb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [TAG_W-1:0]     in_event_tag,
  input  logic [FLAG_W-1:0]    in_event_flags,
  input  logic [PAYLOAD_W-1:0] in_event_payload,
  input  logic [TIME_W-1:0]    in_event_time,
  input  logic [LIMIT_W-1:0]   in_read_limit,
  input  logic                 q_full,
  output logic                 q_push,
  output item_t                q_item
);

  logic [LIMIT_W-1:0] limit_clamped;
  logic               zero_read;
  logic               accept;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  assign limit_clamped = (in_read_limit > LIMIT_W'(MAX_READ)) ? LIMIT_W'(MAX_READ)
                                                              : in_read_limit;
  // a read with no room returns nothing and changes nothing
  assign zero_read = (cmd_t'(in_command) == CMD_READ) && (in_read_limit == '0);

  assign q_push = accept & ~zero_read;

  always_comb begin
    q_item.kind    = cmd_t'(in_command);
    q_item.tag     = in_event_tag;
    q_item.flags   = in_event_flags;
    q_item.payload = in_event_payload;
    q_item.stamp   = in_event_time;
    q_item.limit   = limit_clamped;
  end

  // pushes only happen when the queue has room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_no_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_item.kind == CMD_READ) |-> (q_item.limit != '0))
    else $error("empty read queued");

  a_limit_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_item.limit <= LIMIT_W'(MAX_READ)))
    else $error("read limit not clamped");

endmodule

@@ src/etrb_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// etrb_cmd_fifo
// short command queue decoupling the front from the back
// ----------------------------------------------------------------------------
module etrb_cmd_fifo import etrb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head_item
);

  item_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;

  assign full      = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QUEUE_AW + 1)'(1);
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (QUEUE_AW + 1)'(1)))
    else $error("queue count missed a push");

endmodule

@@ src/etrb_back.sv @@
// ----------------------------------------------------------------------------
// etrb_back
// executes records and reads against the ring, sequence table and lost counter
// ----------------------------------------------------------------------------
module etrb_back import etrb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CFG_W-1:0]     tracked_tags,
  input  logic                 q_valid,
  input  item_t                q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TAG_W-1:0]     out_tag,
  output logic [FLAG_W-1:0]    out_flags,
  output logic [PAYLOAD_W-1:0] out_payload,
  output logic [TIME_W-1:0]    out_time,
  output logic [SEQ_W-1:0]     out_sequence,
  output logic                 out_last_of_read,
  output logic                 out_more_pending
);

  // ring storage, no reset: reads only reach written slots
  logic [TAG_W-1:0]     ring_tag_r   [RING_DEPTH];
  logic [FLAG_W-1:0]    ring_flags_r [RING_DEPTH];
  logic [PAYLOAD_W-1:0] ring_pay_r   [RING_DEPTH];
  logic [TIME_W-1:0]    ring_time_r  [RING_DEPTH];
  logic [SEQ_W-1:0]     ring_seq_r   [RING_DEPTH];

  logic [SEQ_W-1:0]     seq_tab_r [TAG_SLOTS];

  bk_state_t            state_r, state_nxt;
  logic [RING_AW-1:0]   wr_idx_r;
  logic [RING_AW-1:0]   rd_idx_r;
  logic [PAYLOAD_W-1:0] lost_r;
  logic [LIMIT_W-1:0]   rem_r;
  logic                 lost_pend_r;
  logic                 more_r;
  logic                 out_valid_r;

  logic                 out_load;
  logic                 emit;
  logic                 rec_we;
  logic                 rd_start;

  // record path
  logic [TAG_W-1:0]     limit_tags;
  logic                 tag_tracked;
  logic [TAG_AW-1:0]    tag_idx;
  logic [SEQ_W-1:0]     seq_val;
  logic [RING_AW-1:0]   wr_next;

  // read setup
  logic [RING_AW-1:0]   occupancy;
  logic                 lost_flag;
  logic [LIMIT_W-1:0]   rec_slots;
  logic [LIMIT_W-1:0]   occ_ext;
  logic [LIMIT_W-1:0]   drain;
  logic [LIMIT_W-1:0]   total;

  assign limit_tags  = (TAG_W'(tracked_tags) > TAG_W'(TAG_SLOTS)) ? TAG_W'(TAG_SLOTS)
                                                                  : TAG_W'(tracked_tags);
  assign tag_tracked = (q_item.tag < limit_tags);
  assign tag_idx     = q_item.tag[TAG_AW-1:0];
  assign seq_val     = tag_tracked ? seq_tab_r[tag_idx] : '0;
  assign wr_next     = next_ring_idx(wr_idx_r);

  assign occupancy = (wr_idx_r >= rd_idx_r) ? (wr_idx_r - rd_idx_r)
                                            : (wr_idx_r + RING_AW'(RING_DEPTH) - rd_idx_r);
  assign lost_flag = (lost_r != '0);
  assign rec_slots = q_item.limit - LIMIT_W'(lost_flag);
  assign occ_ext   = LIMIT_W'(occupancy);
  assign drain     = (occ_ext < rec_slots) ? occ_ext : rec_slots;
  assign total     = drain + LIMIT_W'(lost_flag);

  assign out_load = ~out_valid_r | out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_item.kind == CMD_READ && total != '0) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        if (out_load && rem_r == LIMIT_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    rec_we   = 1'b0;
    rd_start = 1'b0;
    emit     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop    = q_valid;
        rec_we   = q_valid && (q_item.kind == CMD_RECORD);
        rd_start = q_valid && (q_item.kind == CMD_READ);
      end
      BK_READ: begin
        emit = out_load;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      ring_tag_r[wr_idx_r]   <= q_item.tag;
      ring_flags_r[wr_idx_r] <= q_item.flags;
      ring_pay_r[wr_idx_r]   <= q_item.payload;
      ring_time_r[wr_idx_r]  <= q_item.stamp;
      ring_seq_r[wr_idx_r]   <= seq_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      lost_r      <= '0;
      rem_r       <= '0;
      lost_pend_r <= 1'b0;
      more_r      <= 1'b0;
      for (int i = 0; i < TAG_SLOTS; i++) begin
        seq_tab_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (rec_we) begin
        wr_idx_r <= wr_next;
        if (tag_tracked) begin
          seq_tab_r[tag_idx] <= seq_val + SEQ_W'(1);
        end
        // ring full: drop the oldest record
        if (wr_next == rd_idx_r) begin
          rd_idx_r <= next_ring_idx(rd_idx_r);
          if (lost_r < LOST_MAX) begin
            lost_r <= lost_r + PAYLOAD_W'(1);
          end
        end
      end
      if (rd_start) begin
        rem_r       <= total;
        lost_pend_r <= lost_flag;
        more_r      <= (occ_ext > drain);
      end
      if (emit) begin
        rem_r <= rem_r - LIMIT_W'(1);
        if (lost_pend_r) begin
          lost_pend_r <= 1'b0;
          lost_r      <= '0;
        end else begin
          rd_idx_r <= next_ring_idx(rd_idx_r);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_last_of_read <= (rem_r == LIMIT_W'(1));
      out_more_pending <= more_r;
      if (lost_pend_r) begin
        out_tag      <= '0;
        out_flags    <= '0;
        out_payload  <= lost_r;
        out_time     <= '0;
        out_sequence <= '0;
      end else begin
        out_tag      <= ring_tag_r[rd_idx_r];
        out_flags    <= ring_flags_r[rd_idx_r];
        out_payload  <= ring_pay_r[rd_idx_r];
        out_time     <= ring_time_r[rd_idx_r];
        out_sequence <= ring_seq_r[rd_idx_r];
      end
    end
  end

  assign out_valid = out_valid_r;

  a_read_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ) |-> (rem_r != '0))
    else $error("read running with no beats left");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && rem_r == LIMIT_W'(1)) |=> (state_r == BK_IDLE))
    else $error("read did not end after last beat");

  a_lost_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && lost_pend_r) |=> (lost_r == '0))
    else $error("lost count kept after lost report");

  a_ring_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    rec_we |=> (wr_idx_r != rd_idx_r))
    else $error("ring lost its free slot");

endmodule

@@ src/event_trace_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// event_trace_ring_buffer
// overwriting circular trace buffer with per-tag sequence numbers
// ----------------------------------------------------------------------------
// A record beat (command 0) stores tag, flags, payload, timestamp and a
// sequence number into a 16-slot ring that keeps at most 15 records; when it
// is full the oldest record is dropped and a saturating lost counter rises.
// Tags below tracked_tags (capped at 8) get their own incrementing sequence,
// all others store sequence 0. A read beat (command 1) with a limit returns
// first a lost report (tag, flags, time and sequence 0, payload = lost count)
// if anything was lost, then the oldest records, all within the limit (capped
// at 64); a zero limit returns nothing. out_last_of_read marks the final beat
// of a read and out_more_pending is set on every beat of a read that leaves
// records behind. Input beats go through a two-entry command queue, so the
// front accepts while the back is busy. The back unit executes one command
// at a time: a record is stored as it is popped, a read is set up as it is
// popped and then returns its result beats one by one while the output
// register is drained. tracked_tags is to be written by the user through the
// cfg port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer import etrb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_tracked_tags,
  // command beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [TAG_W-1:0]     in_event_tag,
  input  logic [FLAG_W-1:0]    in_event_flags,
  input  logic [PAYLOAD_W-1:0] in_event_payload,
  input  logic [TIME_W-1:0]    in_event_time,
  input  logic [LIMIT_W-1:0]   in_read_limit,
  // result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TAG_W-1:0]     out_tag,
  output logic [FLAG_W-1:0]    out_flags,
  output logic [PAYLOAD_W-1:0] out_payload,
  output logic [TIME_W-1:0]    out_time,
  output logic [SEQ_W-1:0]     out_sequence,
  output logic                 out_last_of_read,
  output logic                 out_more_pending
);

  logic [CFG_W-1:0] tracked_tags_r;

  // queue wiring between front and back
  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_head_item;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_tags_r <= '0;
    end else if (cfg_valid) begin
      tracked_tags_r <= cfg_tracked_tags;
    end
  end

  // front: accept and classify
  etrb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_event_tag     (in_event_tag),
    .in_event_flags   (in_event_flags),
    .in_event_payload (in_event_payload),
    .in_event_time    (in_event_time),
    .in_read_limit    (in_read_limit),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (q_push_item)
  );

  // command queue
  etrb_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head_item)
  );

  // back: ring, sequence table, lost counter and result register
  etrb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tracked_tags     (tracked_tags_r),
    .q_valid          (q_not_empty),
    .q_item           (q_head_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tag          (out_tag),
    .out_flags        (out_flags),
    .out_payload      (out_payload),
    .out_time         (out_time),
    .out_sequence     (out_sequence),
    .out_last_of_read (out_last_of_read),
    .out_more_pending (out_more_pending)
  );

endmodule

@@ test/event_trace_ring_buffer_test.sv @@
// ----------------------------------------------------------------------------
// event_trace_ring_buffer_test
// self-checking testbench for the overwriting trace ring buffer
// ----------------------------------------------------------------------------
// Commands are pushed through the in_ channel. A behavioral copy of the ring,
// the tag sequence table and the lost counter is updated on every accepted
// beat, and each read queues the result beats it should produce. A monitor
// checks every out_ beat field by field against the oldest queued beat.
// Directed tests cover empty reads, field extremes, the tag count cap and
// overflow with lost reports. Random traffic then runs in phases with and
// without idle cycles on both sides and with a tracked_tags setting written
// at the start of each phase.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer_test;
  import etrb_pkg::*;

  localparam int SETTLE_CYCLES = 16;      // command queue plus back unit, with margin
  localparam int LIMIT_CYCLES  = 200_000;
  localparam int PHASE_ITEMS   = 43;

  // one result beat, also used for the ring copy (last/more unused there)
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [FLAG_W-1:0]    flags;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    stamp;
    logic [SEQ_W-1:0]     seq;
    logic                 last;
    logic                 more;
  } trace_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_tracked_tags = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = '0;
  logic [TAG_W-1:0]     in_event_tag = '0;
  logic [FLAG_W-1:0]    in_event_flags = '0;
  logic [PAYLOAD_W-1:0] in_event_payload = '0;
  logic [TIME_W-1:0]    in_event_time = '0;
  logic [LIMIT_W-1:0]   in_read_limit = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TAG_W-1:0]     out_tag;
  logic [FLAG_W-1:0]    out_flags;
  logic [PAYLOAD_W-1:0] out_payload;
  logic [TIME_W-1:0]    out_time;
  logic [SEQ_W-1:0]     out_sequence;
  logic                 out_last_of_read;
  logic                 out_more_pending;

  // copy of the block state
  trace_beat_t          ring_copy [RING_DEPTH];
  logic [SEQ_W-1:0]     tag_seq [TAG_SLOTS];
  logic [RING_AW-1:0]   wr_idx;
  logic [RING_AW-1:0]   rd_idx;
  logic [PAYLOAD_W-1:0] lost_count;
  logic [CFG_W-1:0]     tracked_setting;

  // read beats still to come out of the block, oldest first
  trace_beat_t          due_beats [$];

  // idle/stall percentages of the current phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned records_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned lost_reports_due = 0;
  int unsigned cfg_writes = 0;

  event_trace_ring_buffer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_tracked_tags (cfg_tracked_tags),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_event_tag     (in_event_tag),
    .in_event_flags   (in_event_flags),
    .in_event_payload (in_event_payload),
    .in_event_time    (in_event_time),
    .in_read_limit    (in_read_limit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tag          (out_tag),
    .out_flags        (out_flags),
    .out_payload      (out_payload),
    .out_time         (out_time),
    .out_sequence     (out_sequence),
    .out_last_of_read (out_last_of_read),
    .out_more_pending (out_more_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run limit of %0d cycles reached, %0d beats still due",
               $time, LIMIT_CYCLES, due_beats.size());
      $display("** event_trace_ring_buffer: FAILED **");
      $finish;
    end
  end

  // receiver backpressure, one draw per cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // result monitor: every out_ beat against the oldest due beat
  always @(posedge clk) begin
    trace_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_beats.size() == 0) begin
        error_count++;
        $display("%0t: beat with nothing due, tag 0x%0h payload 0x%0h seq %0d",
                 $time, out_tag, out_payload, out_sequence);
      end else begin
        want = due_beats.pop_front();
        beats_checked++;
        check_field("out_tag", want.tag, out_tag);
        check_field("out_flags", want.flags, out_flags);
        check_field("out_payload", want.payload, out_payload);
        check_field("out_time", want.stamp, out_time);
        check_field("out_sequence", want.seq, out_sequence);
        check_field("out_last_of_read", want.last, out_last_of_read);
        check_field("out_more_pending", want.more, out_more_pending);
      end
    end
  end

  // update the state copy for one accepted command, queue any read beats
  task automatic mirror_command(input cmd_t kind, input logic [TAG_W-1:0] tag,
                                input logic [FLAG_W-1:0] flags,
                                input logic [PAYLOAD_W-1:0] payload,
                                input logic [TIME_W-1:0] stamp,
                                input logic [LIMIT_W-1:0] limit);
    int unsigned tag_cap;
    int unsigned read_cap;
    logic [SEQ_W-1:0] seq;
    trace_beat_t beat;
    trace_beat_t batch [$];
    if (kind == CMD_RECORD) begin
      records_sent++;
      // register values above the table size act as the table size
      tag_cap = (tracked_setting > TAG_SLOTS) ? TAG_SLOTS : tracked_setting;
      seq = '0;
      if (tag < tag_cap) begin
        seq = tag_seq[tag[TAG_AW-1:0]];
        tag_seq[tag[TAG_AW-1:0]] = seq + 1'b1;
      end
      beat = '0;
      beat.tag = tag;
      beat.flags = flags;
      beat.payload = payload;
      beat.stamp = stamp;
      beat.seq = seq;
      ring_copy[wr_idx] = beat;
      wr_idx = next_ring_idx(wr_idx);
      // ring full: oldest record is dropped
      if (wr_idx == rd_idx) begin
        rd_idx = next_ring_idx(rd_idx);
        if (lost_count != LOST_MAX) begin
          lost_count = lost_count + 1'b1;
        end
      end
    end else begin
      reads_sent++;
      read_cap = (limit > MAX_READ) ? MAX_READ : limit;
      if (read_cap != 0) begin
        // lost report goes first and counts toward the limit
        if (lost_count != 0) begin
          beat = '0;
          beat.payload = lost_count;
          batch.push_back(beat);
          lost_count = '0;
          lost_reports_due++;
        end
        while (batch.size() < read_cap && rd_idx != wr_idx) begin
          batch.push_back(ring_copy[rd_idx]);
          rd_idx = next_ring_idx(rd_idx);
        end
        foreach (batch[k]) begin
          batch[k].more = (rd_idx != wr_idx);
          batch[k].last = (k == batch.size() - 1);
          due_beats.push_back(batch[k]);
        end
      end
    end
  endtask

  // one command beat; called at a falling edge, returns at a falling edge
  task automatic send_command(input cmd_t kind, input logic [TAG_W-1:0] tag,
                              input logic [FLAG_W-1:0] flags,
                              input logic [PAYLOAD_W-1:0] payload,
                              input logic [TIME_W-1:0] stamp,
                              input logic [LIMIT_W-1:0] limit);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command = kind;
    in_event_tag = tag;
    in_event_flags = flags;
    in_event_payload = payload;
    in_event_time = stamp;
    in_read_limit = limit;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    mirror_command(kind, tag, flags, payload, stamp, limit);
    @(negedge clk);
  endtask

  task automatic send_record(input logic [TAG_W-1:0] tag, input logic [FLAG_W-1:0] flags,
                             input logic [PAYLOAD_W-1:0] payload,
                             input logic [TIME_W-1:0] stamp);
    send_command(CMD_RECORD, tag, flags, payload, stamp, LIMIT_W'($urandom));
  endtask

  task automatic send_read(input logic [LIMIT_W-1:0] limit);
    send_command(CMD_READ, TAG_W'($urandom), FLAG_W'($urandom), $urandom, $urandom, limit);
  endtask

  // drop valid, let every due beat arrive, then let trailing records finish
  task automatic settle();
    in_valid = 1'b0;
    while (due_beats.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_tracked_tags(input logic [CFG_W-1:0] value);
    settle();
    cfg_tracked_tags = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tracked_setting = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // nothing stored and nothing lost: reads return no beats
  task automatic test_empty_reads();
    send_read(LIMIT_W'(64));
    send_read('0);
    settle();
  endtask

  // extreme field values, tracked and untracked tags, limit handling
  task automatic test_field_extremes();
    write_tracked_tags(CFG_W'(3));
    send_record(8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_record(8'h00, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(8'h01, 8'h5A, 32'hA5A5_5A5A, 32'h0000_0001);
    send_record(8'h02, 8'h81, 32'h8000_0001, 32'h8000_0000);
    send_record(8'h03, 8'h3C, 32'h1234_5678, 32'h7FFF_FFFF);  // just past the tracked range
    send_record(8'hFF, 8'hA5, 32'h0000_0001, 32'hFFFF_FFFE);
    send_read(LIMIT_W'(2));    // partial read, records stay behind
    send_read('0);             // zero limit, no effect
    send_read(LIMIT_W'(127));  // oversize limit, capped
    settle();
  endtask

  // tracked_tags above the table size acts as the table size
  task automatic test_tag_cap();
    write_tracked_tags(CFG_W'(15));
    send_record(8'h07, 8'h11, $urandom, $urandom);
    send_record(8'h08, 8'h22, $urandom, $urandom);
    send_record(8'h07, 8'h33, $urandom, $urandom);
    write_tracked_tags(CFG_W'(8));
    send_record(8'h07, 8'h44, $urandom, $urandom);
    write_tracked_tags(CFG_W'(0));
    send_record(8'h00, 8'h55, $urandom, $urandom);  // nothing tracked
    send_read(LIMIT_W'(64));
    settle();
  endtask

  // overfill the ring, then read the lost report alone and drain the rest
  task automatic test_ring_overflow();
    write_tracked_tags(CFG_W'(4));
    repeat (RING_DEPTH + 1) begin
      send_record(TAG_W'($urandom_range(0, 5)), FLAG_W'($urandom), $urandom, $urandom);
    end
    send_read(LIMIT_W'(1));
    send_read(LIMIT_W'(64));
    settle();
  endtask

  // random mix, mostly small tags so tracked counters get exercised
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [CFG_W-1:0] setting);
    logic [LIMIT_W-1:0] limit;
    logic [TAG_W-1:0] tag;
    write_tracked_tags(setting);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 99) < 75) begin
          tag = TAG_W'($urandom_range(0, 9));
        end else begin
          tag = TAG_W'($urandom);
        end
        send_record(tag, FLAG_W'($urandom), $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            limit = '0;
          end
          1, 2: begin
            limit = LIMIT_W'($urandom_range(MAX_READ + 1, 127));
          end
          default: begin
            limit = LIMIT_W'($urandom_range(1, 20));
          end
        endcase
        send_read(limit);
      end
    end
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    foreach (tag_seq[t]) tag_seq[t] = '0;
    foreach (ring_copy[s]) ring_copy[s] = '0;
    wr_idx = '0;
    rd_idx = '0;
    lost_count = '0;
    tracked_setting = '0;

    // synchronous reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_reads();
    test_field_extremes();
    test_tag_cap();
    test_ring_overflow();
    test_random_traffic(0, 0, CFG_W'(8));
    test_random_traffic(78, 0, CFG_W'($urandom_range(1, 7)));
    test_random_traffic(0, 78, CFG_W'(15));
    test_random_traffic(19, 19, CFG_W'($urandom_range(0, 15)));
    settle();

    $display("covered %0d records and %0d reads over %0d tracked_tags writes",
             records_sent, reads_sent, cfg_writes);
    $display("checked %0d result beats, %0d of them lost reports, in %0d cycles",
             beats_checked, lost_reports_due, cycle_count);
    if (error_count == 0) begin
      $display("** event_trace_ring_buffer: PASSED **");
    end else begin
      $display("%0d mismatches", error_count);
      $display("** event_trace_ring_buffer: FAILED **");
    end
    $finish;
  end

endmodule
